### design/mml_ntp_pkg.sv
// ----------------------------------------------------------------------------
// mml_ntp_pkg
// Shared types and constants of the music-macro note token parser.
// ----------------------------------------------------------------------------
package mml_ntp_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CFG_TEMPO    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEF_LEN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_OCT = 2'd2;

  localparam logic [9:0] TEMPO_RST    = 10'd120;
  localparam logic [6:0] DEF_LEN_RST  = 7'd4;
  localparam logic [3:0] BASE_OCT_RST = 4'd4;
  localparam logic [9:0] MIN_TEMPO    = 10'd4;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [15:0] LEN_SAT    = 16'hFFFF;

  // divider
  localparam int unsigned DivW = 16;
  localparam logic [3:0] DIV_LAST_STEP = 4'(DivW - 1);

  // command queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);
  localparam int unsigned FifoCw = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_NOTE = 2'd0,
    KIND_REST = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_SHARP = 2'd1,
    ACC_FLAT  = 2'd2
  } acc_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  letter;
    acc_e        acc;
    logic [15:0] len;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [9:0] tempo;
    logic [6:0] def_len;
    logic [3:0] base_oct;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### design/mml_ntp_if.sv
// ----------------------------------------------------------------------------
// mml_ntp_if
// Valid/ready channels for text bytes in and token events out.
// ----------------------------------------------------------------------------
interface mml_ntp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface mml_ntp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  letter_code;
  logic        sharp_mark;
  logic        flat_mark;
  logic [6:0]  tone_idx;
  logic [15:0] duration_ms;
  logic        last_of_run;

  modport source (
    output valid, output event_kind, output letter_code, output sharp_mark,
    output flat_mark, output tone_idx, output duration_ms, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input event_kind, input letter_code, input sharp_mark,
    input flat_mark, input tone_idx, input duration_ms, input last_of_run,
    output ready
  );
endinterface

### design/mml_ntp_front.sv
// ----------------------------------------------------------------------------
// mml_ntp_front
// Byte classifier and token tracker; queues up to three commands per byte.
// ----------------------------------------------------------------------------
module mml_ntp_front import mml_ntp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mml_ntp_in_if.sink   in_if,
  output logic         push_o,
  output cmd_t         push_cmd_o,
  input  logic         full_i
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LETTER = 3'b010,
    PH_DIGITS = 3'b100
  } phase_e;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  phase_e      phase_q, phase_d;
  logic [2:0]  letter_q, letter_d;
  logic        rest_q, rest_d;
  acc_e        acc_q, acc_d;
  logic [15:0] len_q, len_d;
  cmd_t        slot_q [3];
  cmd_t        slot_d [3];
  logic [2:0]  slot_v_q, slot_v_d;

  logic        accept;
  logic [7:0]  byte_up;
  logic        is_digit;
  logic        is_acc;
  logic        is_letter;
  logic        is_rest;
  logic        consumed;
  logic [19:0] len_mul;

  function automatic cmd_t make_cmd(input logic rest, input logic [2:0] letter,
                                    input acc_e acc, input logic [15:0] len);
    cmd_t c;
    c.kind   = rest ? KIND_REST : KIND_NOTE;
    c.letter = letter;
    c.acc    = acc;
    c.len    = len;
    c.last   = 1'b0;
    return c;
  endfunction

  assign in_if.ready = ~(|slot_v_q);
  assign accept      = in_if.valid & in_if.ready;

  assign byte_up   = (in_if.text_byte >= CH_LO_A && in_if.text_byte <= CH_LO_Z) ?
                     in_if.text_byte - CASE_GAP : in_if.text_byte;
  assign is_digit  = in_if.text_byte >= CH_ZERO && in_if.text_byte <= CH_NINE;
  assign is_acc    = in_if.text_byte == CH_PLUS || in_if.text_byte == CH_HASH ||
                     in_if.text_byte == CH_MINUS;
  assign is_letter = byte_up >= CH_UP_A && byte_up <= CH_UP_G;
  assign is_rest   = byte_up == CH_UP_R || byte_up == CH_UP_P;
  assign len_mul   = {4'd0, len_q} * 20'd10 + {16'd0, in_if.text_byte[3:0]};

  // drain the slots in order, one transfer into the queue per cycle while the queue is not full
  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = slot_q[2];
    if (slot_v_q[0]) begin
      push_cmd_o = slot_q[0];
    end else if (slot_v_q[1]) begin
      push_cmd_o = slot_q[1];
    end
    if (|slot_v_q && !full_i) begin
      push_o = 1'b1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    rest_d   = rest_q;
    acc_d    = acc_q;
    len_d    = len_q;
    slot_d   = slot_q;
    slot_v_d = slot_v_q;
    consumed = 1'b0;

    if (push_o) begin
      if (slot_v_q[0]) begin
        slot_v_d[0] = 1'b0;
      end else if (slot_v_q[1]) begin
        slot_v_d[1] = 1'b0;
      end else begin
        slot_v_d[2] = 1'b0;
      end
    end

    if (accept) begin
      if (phase_q == PH_LETTER && is_acc) begin
        acc_d    = (in_if.text_byte == CH_MINUS) ? ACC_FLAT : ACC_SHARP;
        phase_d  = PH_DIGITS;
        consumed = 1'b1;
      end else if (phase_q != PH_IDLE && is_digit) begin
        len_d    = (|len_mul[19:16]) ? LEN_SAT : len_mul[15:0];
        phase_d  = PH_DIGITS;
        consumed = 1'b1;
      end else if (phase_q != PH_IDLE) begin
        slot_d[0]      = make_cmd(rest_q, letter_q, acc_q, len_q);
        slot_d[0].last = ~in_if.end_of_text;
        slot_v_d[0]    = 1'b1;
        phase_d        = PH_IDLE;
        letter_d       = 3'd0;
        rest_d         = 1'b0;
        acc_d          = ACC_NONE;
        len_d          = 16'd0;
      end

      if (!consumed && (is_letter || is_rest)) begin
        phase_d  = is_letter ? PH_LETTER : PH_DIGITS;
        letter_d = is_letter ? 3'(byte_up - CH_UP_A) : 3'd0;
        rest_d   = is_rest;
        acc_d    = ACC_NONE;
        len_d    = 16'd0;
      end

      // end of text flushes the token still open, then the end marker
      if (in_if.end_of_text) begin
        if (phase_d != PH_IDLE) begin
          slot_d[1]   = make_cmd(rest_d, letter_d, acc_d, len_d);
          slot_v_d[1] = 1'b1;
        end
        slot_d[2]        = make_cmd(1'b0, 3'd0, ACC_NONE, 16'd0);
        slot_d[2].kind   = KIND_END;
        slot_d[2].last   = 1'b1;
        slot_v_d[2]      = 1'b1;
        phase_d          = PH_IDLE;
        letter_d         = 3'd0;
        rest_d           = 1'b0;
        acc_d            = ACC_NONE;
        len_d            = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      letter_q <= 3'd0;
      rest_q   <= 1'b0;
      acc_q    <= ACC_NONE;
      len_q    <= 16'd0;
      slot_v_q <= 3'b000;
    end else begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      rest_q   <= rest_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      slot_v_q <= slot_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef SYNTHESIS
  a_flush_has_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_v_q[1] |-> slot_v_q[2])
    else $error("flushed token queued without end marker");

  a_eot_queues_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.end_of_text) |=> (slot_v_q[2] && phase_q == PH_IDLE))
    else $error("end of text did not queue end marker and return to idle");

  a_rest_no_letter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_q |-> (letter_q == 3'd0 && acc_q == ACC_NONE))
    else $error("rest token carries letter or accidental");
`endif

endmodule

### design/mml_ntp_fifo.sv
// ----------------------------------------------------------------------------
// mml_ntp_fifo
// Short command queue between the byte front end and the event back end.
// ----------------------------------------------------------------------------
module mml_ntp_fifo import mml_ntp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCw-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == FifoCw'(FifoDepth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### design/mml_ntp_div.sv
// ----------------------------------------------------------------------------
// mml_ntp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mml_ntp_div import mml_ntp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q;
  logic            done_q;
  logic [3:0]      step_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] quo_q;
  logic [DivW-1:0] dsr_q;
  logic [DivW:0]   shifted;
  logic            ge;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 4'd0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == DIV_LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits carry it
      rem_q <= ge ? DivW'(shifted - {1'b0, dsr_q}) : shifted[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

endmodule

### design/mml_ntp_back.sv
// ----------------------------------------------------------------------------
// mml_ntp_back
// Turns queued commands into events: note index, two divisions for duration.
// ----------------------------------------------------------------------------
module mml_ntp_back import mml_ntp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  cmd_t          head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output div_req_t      div_req_o,
  input  div_rsp_t      div_rsp_i,
  mml_ntp_out_if.source out_if
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cur_q;
  logic [6:0]  idx_q;
  logic [15:0] dur_q;
  logic        out_v_q;
  logic [1:0]  out_kind_q;
  logic [2:0]  out_letter_q;
  logic        out_sharp_q;
  logic        out_flat_q;
  logic [6:0]  out_idx_q;
  logic [15:0] out_dur_q;
  logic        out_last_q;

  logic [9:0]  tempo_eff;
  logic [15:0] len_eff;
  logic        load_out;

  function automatic logic [6:0] tone_idx_of(input logic [2:0] letter, input acc_e acc,
                                             input logic [3:0] oct_in);
    logic signed [8:0] semi;
    logic signed [8:0] oct;
    logic signed [8:0] idx;
    unique case (letter)
      3'd0:    semi = 9'sd9;
      3'd1:    semi = 9'sd11;
      3'd2:    semi = 9'sd0;
      3'd3:    semi = 9'sd2;
      3'd4:    semi = 9'sd4;
      3'd5:    semi = 9'sd5;
      3'd6:    semi = 9'sd7;
      default: semi = 9'sd9;
    endcase
    oct = $signed({5'd0, oct_in});
    if (acc == ACC_SHARP) begin
      semi = semi + 9'sd1;
    end else if (acc == ACC_FLAT) begin
      semi = semi - 9'sd1;
    end
    // accidental wrap moves the octave, but never down below 1 or up above 8
    if (semi < 9'sd0) begin
      semi = semi + 9'sd12;
      if (oct > 9'sd1) begin
        oct = oct - 9'sd1;
      end
    end
    if (semi >= 9'sd12) begin
      semi = semi - 9'sd12;
      if (oct < 9'sd8) begin
        oct = oct + 9'sd1;
      end
    end
    idx = oct * 9'sd12 + semi - 9'sd21;
    if (idx < 9'sd0) begin
      idx = 9'sd0;
    end else if (idx > 9'sd86) begin
      idx = 9'sd86;
    end
    return idx[6:0];
  endfunction

  assign tempo_eff = (cfg_i.tempo < MIN_TEMPO) ? MIN_TEMPO : cfg_i.tempo;
  assign len_eff   = (cur_q.len != 16'd0) ? cur_q.len :
                     (cfg_i.def_len == 7'd0) ? 16'd1 : {9'd0, cfg_i.def_len};

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign load_out = (state_q == S_HOLD) && (!out_v_q || out_if.ready);

  // quarter note first, then scale by four and divide by the length
  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = MS_PER_MIN;
    div_req_o.divisor  = {6'd0, tempo_eff};
    if (pop_o && head_i.kind != KIND_END) begin
      div_req_o.start = 1'b1;
    end else if (state_q == S_DIV1 && div_rsp_i.done) begin
      div_req_o.start    = 1'b1;
      div_req_o.dividend = {div_rsp_i.quotient[13:0], 2'b00};
      div_req_o.divisor  = len_eff;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = (head_i.kind == KIND_END) ? S_HOLD : S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp_i.done) begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp_i.done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_if.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      idx_q <= (head_i.kind == KIND_NOTE) ?
               tone_idx_of(head_i.letter, head_i.acc, cfg_i.base_oct) : 7'd0;
      dur_q <= 16'd0;
    end else if (state_q == S_DIV2 && div_rsp_i.done) begin
      dur_q <= div_rsp_i.quotient;
    end
    if (load_out) begin
      out_kind_q   <= cur_q.kind;
      out_letter_q <= cur_q.letter;
      out_sharp_q  <= cur_q.acc == ACC_SHARP;
      out_flat_q   <= cur_q.acc == ACC_FLAT;
      out_idx_q    <= idx_q;
      out_dur_q    <= dur_q;
      out_last_q   <= cur_q.last;
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.event_kind  = out_kind_q;
  assign out_if.letter_code = out_letter_q;
  assign out_if.sharp_mark  = out_sharp_q;
  assign out_if.flat_mark   = out_flat_q;
  assign out_if.tone_idx    = out_idx_q;
  assign out_if.duration_ms = out_dur_q;
  assign out_if.last_of_run = out_last_q;

`ifndef SYNTHESIS
  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a division phase");

  a_end_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == KIND_END) |-> (out_dur_q == 16'd0 && out_idx_q == 7'd0))
    else $error("end marker with nonzero fields");

  a_rest_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == KIND_REST) |-> (out_idx_q == 7'd0 && out_letter_q == 3'd0))
    else $error("rest with note index or letter");
`endif

endmodule

### design/mml_note_token_parser_unit.sv
// ----------------------------------------------------------------------------
// mml_note_token_parser_unit
// Music-macro text parser: bytes in, note/rest/end events with durations out.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// in_if     in   valid/ready         text_byte, end_of_text
// out_if    out  valid/ready         event_kind .. last_of_run
// cfg       in   cfg_we_i (no wait)  cfg_idx_i, cfg_data_i
//
// the front end takes no new byte until every event queued for the last one
// has gone into the queue; each note or rest in the back end needs two
// 16-step divisions on the shared divider (quarter note, then by length)
// an end marker skips the divider; a 4-entry queue lets bytes run ahead
// reset is asynchronous; no memory, nothing to clear after reset
// ----------------------------------------------------------------------------
module mml_note_token_parser_unit import mml_ntp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  mml_ntp_in_if.sink          in_if,
  mml_ntp_out_if.source       out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [9:0] tempo_q;
  logic [6:0] def_len_q;
  logic [3:0] base_oct_q;
  cfg_t       cfg;

  logic     push;
  cmd_t     push_cmd;
  logic     full;
  logic     pop;
  cmd_t     head;
  logic     empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q    <= TEMPO_RST;
      def_len_q  <= DEF_LEN_RST;
      base_oct_q <= BASE_OCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMPO:    tempo_q    <= cfg_data_i;
        CFG_DEF_LEN:  def_len_q  <= cfg_data_i[6:0];
        CFG_BASE_OCT: base_oct_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.tempo    = tempo_q;
  assign cfg.def_len  = def_len_q;
  assign cfg.base_oct = base_oct_q;

  mml_ntp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  mml_ntp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  mml_ntp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mml_ntp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_if    (out_if)
  );

endmodule
